FILE: rtl/lpfd_pkg.sv
package lpfd_pkg;

   localparam int unsigned HeaderBytes = 10;

   // Expected magic, upper case: "FBEB"
   localparam logic [3:0][7:0] MagicUpper = {8'h42, 8'h45, 8'h42, 8'h46};

   localparam logic [31:0] MaxLengthReset = 32'd4096;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER     = 3'd0,
      KIND_PAYLOAD    = 3'd1,
      KIND_BAD_MAGIC  = 3'd2,
      KIND_BAD_LENGTH = 3'd3,
      KIND_DISCARD    = 3'd4
   } kind_type;

   // request held in the input register
   typedef struct packed {
      logic       valid;
      logic       restart;
      logic [7:0] data_byte;
   } stage_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [15:0] event_id;
      logic [31:0] message_length;
      logic        last;
   } rsp_item_type;

endpackage

FILE: rtl/lpfd_in_stage.sv
module lpfd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte,
   input  logic                 req_restart,
   input  logic                 take,
   output lpfd_pkg::stage_type  stage
);

   logic       valid_ff;
   logic       valid_in;
   logic       restart_ff;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         restart_ff <= req_restart;
         byte_ff    <= req_byte;
      end
   end

   assign stage.valid     = valid_ff;
   assign stage.restart   = restart_ff;
   assign stage.data_byte = byte_ff;

endmodule

FILE: rtl/lpfd_parser.sv
module lpfd_parser #(
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   input  lpfd_pkg::stage_type    stage,
   output logic                   take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lpfd_pkg::rsp_item_type rsp_item
);

   localparam logic [32:0] LenLimit = 33'd1 << LENGTH_WIDTH;

   logic [31:0]               max_len_ff;
   lpfd_pkg::phase_type       phase_ff, phase_in;
   logic [3:0]                hcount_ff, hcount_in;
   logic                      mismatch_ff, mismatch_in;
   logic [15:0]               event_ff, event_in;
   logic [31:0]               flen_ff, flen_in;
   logic [LENGTH_WIDTH-1:0]   pcount_ff, pcount_in;
   logic [LENGTH_WIDTH-1:0]   pcount_inc;
   logic                      rsp_valid_ff, rsp_valid_in;
   lpfd_pkg::rsp_item_type    rsp_ff, rsp_in;
   logic [7:0]                upper_byte;
   logic                      len_ok;

   assign take = stage.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (stage.data_byte inside {[8'h61:8'h7A]}) begin
         upper_byte = stage.data_byte - 8'h20;
      end else begin
         upper_byte = stage.data_byte;
      end
   end

   assign pcount_inc = pcount_ff + 1'b1;

   always_comb begin
      phase_in    = stage.restart ? lpfd_pkg::PH_HEADER : phase_ff;
      hcount_in   = stage.restart ? 4'd0 : hcount_ff;
      mismatch_in = stage.restart ? 1'b0 : mismatch_ff;
      event_in    = event_ff;
      flen_in     = flen_ff;
      pcount_in   = pcount_ff;
      len_ok      = 1'b0;
      rsp_in.kind         = lpfd_pkg::KIND_DISCARD;
      rsp_in.payload_byte = 8'd0;
      rsp_in.last         = 1'b0;

      case (phase_in)
         lpfd_pkg::PH_HEADER: begin
            if (hcount_in == 4'd0) begin
               event_in    = 16'd0;
               flen_in     = 32'd0;
               mismatch_in = 1'b0;
            end
            case (hcount_in)
               4'd0, 4'd1, 4'd2, 4'd3: begin
                  if (upper_byte != lpfd_pkg::MagicUpper[hcount_in[1:0]]) begin
                     mismatch_in = 1'b1;
                  end
               end
               4'd4: event_in[7:0]   = event_in[7:0] | stage.data_byte;
               4'd5: event_in[15:8]  = event_in[15:8] | stage.data_byte;
               4'd6: flen_in[7:0]    = flen_in[7:0] | stage.data_byte;
               4'd7: flen_in[15:8]   = flen_in[15:8] | stage.data_byte;
               4'd8: flen_in[23:16]  = flen_in[23:16] | stage.data_byte;
               4'd9: flen_in[31:24]  = flen_in[31:24] | stage.data_byte;
               default: ;
            endcase
            rsp_in.kind = lpfd_pkg::KIND_HEADER;
            len_ok = (flen_in != 32'd0) && (flen_in <= max_len_ff)
                     && ({1'b0, flen_in} < LenLimit);
            if (hcount_in >= 4'(lpfd_pkg::HeaderBytes - 1)) begin
               hcount_in = 4'd0;
               if (mismatch_in) begin
                  rsp_in.kind = lpfd_pkg::KIND_BAD_MAGIC;
                  phase_in    = lpfd_pkg::PH_DISCARD;
               end else if (!len_ok) begin
                  rsp_in.kind = lpfd_pkg::KIND_BAD_LENGTH;
                  phase_in    = lpfd_pkg::PH_DISCARD;
               end else begin
                  phase_in  = lpfd_pkg::PH_PAYLOAD;
                  pcount_in = '0;
               end
               mismatch_in = 1'b0;
            end else begin
               hcount_in = hcount_in + 4'd1;
            end
         end
         lpfd_pkg::PH_PAYLOAD: begin
            rsp_in.kind         = lpfd_pkg::KIND_PAYLOAD;
            rsp_in.payload_byte = stage.data_byte;
            pcount_in           = pcount_inc;
            if (32'(pcount_inc) >= flen_ff) begin
               rsp_in.last = 1'b1;
               pcount_in   = '0;
               phase_in    = lpfd_pkg::PH_HEADER;
               hcount_in   = 4'd0;
               mismatch_in = 1'b0;
            end
         end
         default: begin
            rsp_in.kind = lpfd_pkg::KIND_DISCARD;
         end
      endcase

      rsp_in.event_id       = event_in;
      rsp_in.message_length = flen_in;
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= lpfd_pkg::MaxLengthReset;
         phase_ff     <= lpfd_pkg::PH_HEADER;
         hcount_ff    <= 4'd0;
         mismatch_ff  <= 1'b0;
         event_ff     <= 16'd0;
         flen_ff      <= 32'd0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         if (take) begin
            phase_ff    <= phase_in;
            hcount_ff   <= hcount_in;
            mismatch_ff <= mismatch_in;
            event_ff    <= event_in;
            flen_ff     <= flen_in;
            pcount_ff   <= pcount_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/length_prefixed_frame_deframer.sv
// channel   dir  handshake              payload
// -------   ---  ---------------------  --------------------------------------------
// req       in   req_tvalid/req_tready  tdata: data_byte; tuser: restart
// rsp       out  rsp_tvalid/rsp_tready  tdata: payload_byte, event_id, message_length;
//                                        tuser: kind; tlast: last
// csr       in   csr_we                 csr_wdata: max_message_length
//
// One request per cycle sustained while rsp_tready is high, one response per request,
// registered in the input register, then parser state and response register.
// Reset is synchronous; it returns the parser to header reading and sets
// max_message_length back to 4096.
// While rsp_tready is low the response holds and the input register takes one
// more request; req_tready then drops until the response is taken.
module length_prefixed_frame_deframer #(
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] payload_byte, [23:8] event_id,
                                    // [55:24] message_length
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,   // last payload byte of a frame
   // configuration
   input  logic        csr_we,
   input  logic [31:0] csr_wdata    // max_message_length
);

   lpfd_pkg::stage_type    stage;
   lpfd_pkg::rsp_item_type rsp_item;
   logic                   take;

   // input register: parts the request side from the parser
   lpfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_byte    (req_tdata),
      .req_restart (req_tuser[0]),
      .take        (take),
      .stage       (stage)
   );

   // header/payload parser, frame state and response register
   lpfd_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .take      (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {rsp_item.message_length, rsp_item.event_id, rsp_item.payload_byte};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

`ifndef SYNTHESIS
   // last only ever marks a payload byte
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == lpfd_pkg::KIND_PAYLOAD)
      else $error("tlast on a non-payload response");

   // payload byte field is zero outside payload responses
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != lpfd_pkg::KIND_PAYLOAD) |-> rsp_tdata[7:0] == 8'd0)
      else $error("payload byte set on a non-payload response");

   // backpressure only when both the input register and the response are held
   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled response");
`endif

endmodule
